[hw/rtl/utf8_to_utf16_stream_decoder_top_defines.svh]
// Assertion macros used by the checker file of the UTF-8 to UTF-16 decoder.
`ifndef UTF8_TO_UTF16_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("u8u16 check failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("u8u16 check failed");

`endif

[hw/rtl/u8u16_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
package u8u16_pkg;

  localparam logic [7:0]  AsciiMask   = 8'h80;
  localparam logic [7:0]  Lead3Mask   = 8'hF0;
  localparam logic [7:0]  Lead3Value  = 8'hE0;
  localparam logic [7:0]  Lead2Mask   = 8'hE0;
  localparam logic [7:0]  Lead2Value  = 8'hC0;
  localparam logic [7:0]  LeadBits    = 8'h1F;
  localparam logic [7:0]  ContBits    = 8'h3F;
  localparam logic [15:0] Replacement = 16'h003F;
  localparam logic [15:0] MaxUnitsRst = 16'hFFFF;

  // Number of results one byte produces.
  localparam logic [1:0] NoResult  = 2'd0;
  localparam logic [1:0] OneResult = 2'd1;
  localparam logic [1:0] TwoResult = 2'd2;

  // Continuation bytes still expected.
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_end;
    logic [15:0] unit_count;
  } res_t;

  typedef struct packed {
    logic [1:0]  bytes_pending;
    logic [15:0] accumulator;
    logic [15:0] units_emitted;
    logic        limit_reached;
  } dec_state_t;

endpackage

[hw/rtl/u8u16_dec.sv]
`timescale 1ns / 1ps
// Per-byte decode step: next string state and up to two results.
module u8u16_dec (
  input  u8u16_pkg::dec_state_t state_i,
  input  logic [15:0]           max_units_i,
  input  logic [7:0]            in_byte_i,
  output u8u16_pkg::dec_state_t state_o,
  output logic [1:0]            num_res_o,
  output u8u16_pkg::res_t       res0_o,
  output u8u16_pkg::res_t       res1_o
);
  import u8u16_pkg::*;

  logic [15:0] acc_or;
  logic [15:0] ue_inc;
  logic [15:0] lead_acc;

  assign acc_or   = state_i.accumulator | {10'd0, in_byte_i[5:0] & ContBits[5:0]};
  assign ue_inc   = 16'(state_i.units_emitted + 16'd1);
  assign lead_acc = {5'd0, in_byte_i[4:0] & LeadBits[4:0], 6'd0};

  always_comb begin
    state_o   = state_i;
    num_res_o = NoResult;
    res0_o    = '0;
    res1_o    = '0;
    if (in_byte_i == 8'd0) begin
      // Flush any partial unit, then the terminator; clear the string.
      state_o = '0;
      if (state_i.bytes_pending != PendNone) begin
        num_res_o          = TwoResult;
        res0_o.code_unit   = state_i.accumulator;
        res1_o.is_end      = 1'b1;
        res1_o.unit_count  = ue_inc;
      end else begin
        num_res_o         = OneResult;
        res0_o.is_end     = 1'b1;
        res0_o.unit_count = state_i.units_emitted;
      end
    end else if (state_i.bytes_pending != PendNone) begin
      // Take any nonzero byte as a continuation.
      state_o.bytes_pending = 2'(state_i.bytes_pending - 2'd1);
      if (state_i.bytes_pending == PendOne) begin
        num_res_o             = OneResult;
        res0_o.code_unit      = acc_or;
        state_o.units_emitted = ue_inc;
        state_o.accumulator   = '0;
      end else begin
        state_o.accumulator = {acc_or[9:0], 6'd0};
      end
    end else if (state_i.limit_reached || (state_i.units_emitted >= max_units_i)) begin
      state_o.limit_reached = 1'b1;
    end else if ((in_byte_i & AsciiMask) == 8'd0) begin
      num_res_o             = OneResult;
      res0_o.code_unit      = {8'd0, in_byte_i};
      state_o.units_emitted = ue_inc;
    end else if ((in_byte_i & Lead2Mask) == Lead2Value) begin
      state_o.accumulator   = lead_acc;
      state_o.bytes_pending = PendOne;
    end else if ((in_byte_i & Lead3Mask) == Lead3Value) begin
      state_o.accumulator   = lead_acc;
      state_o.bytes_pending = PendTwo;
    end else begin
      num_res_o             = OneResult;
      res0_o.code_unit      = Replacement;
      state_o.units_emitted = ue_inc;
    end
  end

endmodule

[hw/rtl/u8u16_fifo.sv]
`timescale 1ns / 1ps
// Four-entry result queue taking up to two results per cycle.
module u8u16_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_cnt_i,
  input  u8u16_pkg::res_t push0_i,
  input  u8u16_pkg::res_t push1_i,
  output logic            space_o,
  input  logic            pop_i,
  output logic            valid_o,
  output u8u16_pkg::res_t head_o
);
  import u8u16_pkg::*;

  res_t        mem_q [4];
  logic [1:0]  wr_ptr_q, wr_ptr_d;
  logic [1:0]  rd_ptr_q, rd_ptr_d;
  logic [2:0]  count_q, count_d;
  logic        do_pop;

  assign valid_o = (count_q != 3'd0);
  assign space_o = (count_q <= 3'd2);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = 2'(wr_ptr_q + push_cnt_i);
    rd_ptr_d = do_pop ? 2'(rd_ptr_q + 2'd1) : rd_ptr_q;
    count_d  = 3'(count_q + {1'b0, push_cnt_i} - {2'd0, do_pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != NoResult) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == TwoResult) begin
      mem_q[2'(wr_ptr_q + 2'd1)] <= push1_i;
    end
  end

endmodule

[hw/rtl/utf8_to_utf16_stream_decoder_top.sv]
`timescale 1ns / 1ps
// Top level of the UTF-8 to UTF-16 stream decoder.
// Results are registered in the result queue and offered on m_axis from its head.
// Throughput: one byte per cycle while the queue has space; a zero byte ending a
//   partial sequence yields two results, sent one by one by the single-read queue.
// Reset (rst_ni low, asynchronous): string state and queue clear, max_units = 65535.
// The queue accepts a byte only while two free slots remain.
module utf8_to_utf16_stream_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: max_units
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // Code unit output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] code_unit, [31:16] unit_count
  output logic        m_axis_tlast    // is_end
);
  import u8u16_pkg::*;

  logic [15:0] max_units_q;
  dec_state_t  state_q, state_d;
  logic [1:0]  num_res;
  logic [1:0]  push_cnt;
  res_t        res0, res1, head;
  logic        in_xfer;
  logic        space;

  // Always ready; unenforced rule: the sender writes only while no byte is in flight.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= MaxUnitsRst;
    end else if (cfg_valid_i) begin
      max_units_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = space;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  u8u16_dec u_dec (
    .state_i     (state_q),
    .max_units_i (max_units_q),
    .in_byte_i   (s_axis_tdata),
    .state_o     (state_d),
    .num_res_o   (num_res),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  // Advance the string state only on a byte transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  assign push_cnt = in_xfer ? num_res : NoResult;

  u8u16_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .space_o    (space),
    .pop_i      (m_axis_tready),
    .valid_o    (m_axis_tvalid),
    .head_o     (head)
  );

  assign m_axis_tdata = {head.unit_count, head.code_unit};
  assign m_axis_tlast = head.is_end;

endmodule

[hw/rtl/u8u16_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the decoder top, with its bind.
`include "utf8_to_utf16_stream_decoder_top_defines.svh"

module u8u16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Hold a stalled result.
  `U8U16_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Terminator carries no code unit.
  `U8U16_ASSERT_NOW(a_end_unit_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tdata[15:0] == 16'd0)

  // Ordinary units carry no count.
  `U8U16_ASSERT_NOW(a_unit_count_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[31:16] == 16'd0)

  // A zero byte always produces a result.
  `U8U16_ASSERT_NEXT(a_zero_gives_result, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tdata == 8'd0), m_axis_tvalid)

endmodule

bind utf8_to_utf16_stream_decoder_top u8u16_checker u_u8u16_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder.
module tb_top;
  import u8u16_pkg::*;

  localparam int ItemsPerPhase = 230;  // minimum bytes transferred per random phase
  localparam int NumPhases     = 6;
  localparam int SettleCycles  = 3;    // results are registered in the queue behind their byte
  localparam int StallLimit    = 4000; // cycles without any transfer before giving up

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  // One line of the directed script: a byte or a max_units write. Where the result
  // is obvious it is written out in `want`; otherwise the predictor supplies it.
  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] value;
    logic        typed;
    res_t        want;
  } script_row_t;

  localparam res_t Blank = '0;
  localparam int NumRows = 27;
  localparam script_row_t Script [NumRows] = '{
    '{ROW_BYTE, 16'h0000, 1'b1, '{16'h0000, 1'b1, 16'h0000}}, // empty string after reset
    '{ROW_BYTE, 16'h0041, 1'b1, '{16'h0041, 1'b0, 16'h0000}},
    '{ROW_BYTE, 16'h007F, 1'b1, '{16'h007F, 1'b0, 16'h0000}}, // top of the ASCII range
    '{ROW_BYTE, 16'h0080, 1'b1, '{16'h003F, 1'b0, 16'h0000}}, // stray continuation as lead
    '{ROW_BYTE, 16'h00FF, 1'b1, '{16'h003F, 1'b0, 16'h0000}}, // illegal lead
    '{ROW_BYTE, 16'h00C3, 1'b0, Blank},
    '{ROW_BYTE, 16'h00A9, 1'b0, Blank},
    '{ROW_BYTE, 16'h00E2, 1'b0, Blank},
    '{ROW_BYTE, 16'h0082, 1'b0, Blank},
    '{ROW_BYTE, 16'h00AC, 1'b0, Blank},
    '{ROW_BYTE, 16'h00EF, 1'b0, Blank}, // largest three-byte value
    '{ROW_BYTE, 16'h00BF, 1'b0, Blank},
    '{ROW_BYTE, 16'h00BF, 1'b0, Blank},
    '{ROW_BYTE, 16'h00C2, 1'b0, Blank}, // lead; the lead-looking byte after it is taken as continuation
    '{ROW_BYTE, 16'h00C3, 1'b0, Blank},
    '{ROW_BYTE, 16'h00E8, 1'b0, Blank}, // string ends inside a sequence
    '{ROW_BYTE, 16'h0000, 1'b0, Blank},
    '{ROW_CFG,  16'h0002, 1'b0, Blank},
    '{ROW_BYTE, 16'h0061, 1'b0, Blank},
    '{ROW_BYTE, 16'h0062, 1'b0, Blank},
    '{ROW_BYTE, 16'h00E2, 1'b0, Blank}, // limit hit on this lead
    '{ROW_BYTE, 16'h0041, 1'b0, Blank},
    '{ROW_BYTE, 16'h0000, 1'b0, Blank},
    '{ROW_CFG,  16'h0000, 1'b0, Blank},
    '{ROW_BYTE, 16'h0041, 1'b0, Blank},
    '{ROW_BYTE, 16'h0000, 1'b1, '{16'h0000, 1'b1, 16'h0000}}, // limit of zero
    '{ROW_CFG,  16'hFFFF, 1'b0, Blank}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [15:0] code_unit, [31:16] unit_count
  logic        m_axis_tlast;         // is_end

  utf8_to_utf16_stream_decoder_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decoder state as the testbench sees it, and the code units still owed by the block.
  dec_state_t  dec_q;
  logic [15:0] max_units_q;
  res_t        unit_slot [2];
  res_t        utf16_units_due [$];
  res_t        oldest_unit;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int fail_count = 0;
  int bytes_sent = 0;
  int units_checked = 0;
  int strings_sent = 0;
  int limit_writes = 0;
  int stall_cycles = 0;

  // Decode one byte into unit_slot; return the number of units, or -1 when the
  // byte is dropped because the string has reached its limit.
  function automatic int decode_utf8_byte(input logic [7:0] b);
    int n;
    n = 0;
    if (b == 8'h00) begin
      // flush a partial sequence first, then close the string
      if (dec_q.bytes_pending != PendNone) begin
        dec_q.units_emitted = dec_q.units_emitted + 16'd1;
        unit_slot[n] = '{code_unit: dec_q.accumulator, is_end: 1'b0, unit_count: 16'h0};
        n++;
      end
      unit_slot[n] = '{code_unit: 16'h0, is_end: 1'b1, unit_count: dec_q.units_emitted};
      n++;
      dec_q = '0;
      return n;
    end
    if (dec_q.bytes_pending != PendNone) begin
      // any nonzero byte continues the sequence; only its low six bits count
      dec_q.accumulator = dec_q.accumulator | {8'h00, b & ContBits};
      dec_q.bytes_pending = dec_q.bytes_pending - 2'd1;
      if (dec_q.bytes_pending == PendNone) begin
        dec_q.units_emitted = dec_q.units_emitted + 16'd1;
        unit_slot[n] = '{code_unit: dec_q.accumulator, is_end: 1'b0, unit_count: 16'h0};
        n++;
        dec_q.accumulator = '0;
      end else begin
        dec_q.accumulator = dec_q.accumulator << 6;
      end
      return n;
    end
    if (dec_q.limit_reached || dec_q.units_emitted >= max_units_q) begin
      dec_q.limit_reached = 1'b1;
      return -1;
    end
    if ((b & AsciiMask) == 8'h00) begin
      dec_q.units_emitted = dec_q.units_emitted + 16'd1;
      unit_slot[n] = '{code_unit: {8'h00, b}, is_end: 1'b0, unit_count: 16'h0};
      n++;
    end else if ((b & Lead2Mask) == Lead2Value) begin
      dec_q.accumulator = {8'h00, b & LeadBits} << 6;
      dec_q.bytes_pending = PendOne;
    end else if ((b & Lead3Mask) == Lead3Value) begin
      // upper lead bits fall off the 16-bit unit later
      dec_q.accumulator = {8'h00, b & LeadBits} << 6;
      dec_q.bytes_pending = PendTwo;
    end else begin
      dec_q.units_emitted = dec_q.units_emitted + 16'd1;
      unit_slot[n] = '{code_unit: Replacement, is_end: 1'b0, unit_count: 16'h0};
      n++;
    end
    return n;
  endfunction

  // Offer one byte, idling first at the current rate, and book its units once
  // the transfer has happened. A typed row replaces the predicted unit.
  task automatic send_byte(input logic [7:0] b, input logic typed, input res_t want);
    int n;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    n = decode_utf8_byte(b);
    if (typed) begin
      utf16_units_due.push_back(want);
    end else begin
      for (int k = 0; k < n; k++) utf16_units_due.push_back(unit_slot[k]);
    end
    bytes_sent++;
    if (b == 8'h00) strings_sent++;
  endtask

  // Hold the input until every owed unit has left, then let the pipe settle.
  task automatic drain_units();
    s_axis_tvalid <= 1'b0;
    while (utf16_units_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_max_units(input logic [15:0] limit);
    drain_units();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    max_units_q = limit;
    limit_writes++;
  endtask

  // Send a byte and count it towards the phase.
  task automatic push_byte(input logic [7:0] b, inout int taken);
    send_byte(b, 1'b0, Blank);
    taken++;
  endtask

  task automatic push_cont(inout int taken);
    push_byte({2'b10, 6'($urandom)}, taken);
  endtask

  // One zero-terminated string: mostly well-formed characters with random content,
  // otherwise noise that may stop half way through a sequence.
  task automatic push_string(inout int taken);
    int chars;
    int pick;
    if ($urandom_range(0, 99) < 80) begin
      chars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      repeat (chars) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          push_byte(8'($urandom_range(1, 127)), taken);
        end else if (pick < 65) begin
          push_byte({3'b110, 5'($urandom)}, taken);
          push_cont(taken);
        end else if (pick < 90) begin
          push_byte({4'b1110, 4'($urandom)}, taken);
          push_cont(taken);
          push_cont(taken);
        end else if ($urandom_range(0, 1) == 0) begin
          push_byte({2'b10, 6'($urandom)}, taken);
        end else begin
          push_byte({4'b1111, 4'($urandom)}, taken);
        end
      end
    end else begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(1, 255)), taken);
      if ($urandom_range(0, 1) == 0) begin
        push_byte({4'b1110, 4'($urandom)}, taken);
        if ($urandom_range(0, 1) == 0) push_cont(taken);
      end
    end
    push_byte(8'h00, taken);
  endtask

  // Receiver side: stall at the current rate.
  always @(posedge clk_i) begin
    m_axis_tready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Compare each transferred result with the oldest owed unit.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (utf16_units_due.size() == 0) begin
        $error("result with nothing owed: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        oldest_unit = utf16_units_due.pop_front();
        if (m_axis_tdata[15:0] !== oldest_unit.code_unit) begin
          $error("code_unit: expected %h, got %h", oldest_unit.code_unit, m_axis_tdata[15:0]);
          fail_count++;
        end
        if (m_axis_tlast !== oldest_unit.is_end) begin
          $error("is_end: expected %b, got %b", oldest_unit.is_end, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tdata[31:16] !== oldest_unit.unit_count) begin
          $error("unit_count: expected %0d, got %0d", oldest_unit.unit_count,
                 m_axis_tdata[31:16]);
          fail_count++;
        end
        units_checked++;
      end
    end
  end

  // Watchdog: give up once nothing has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int taken;
    bit paused;
    logic [15:0] limit;

    dec_q = '0;
    max_units_q = MaxUnitsRst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script, starting from the reset limit.
    for (int r = 0; r < NumRows; r++) begin
      if (Script[r].kind == ROW_CFG) begin
        write_max_units(Script[r].value);
      end else begin
        send_byte(Script[r].value[7:0], Script[r].typed, Script[r].want);
      end
    end

    // Random phases: slow receiver then slow sender, then full rate, each under
    // its own limit. Halfway through a phase, hold the input until all units are out.
    for (int p = 0; p < NumPhases; p++) begin
      case (p / 2)
        0:       begin tx_idle_pct = 25; rx_idle_pct = 79; end
        1:       begin tx_idle_pct = 79; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      case (p)
        0:       limit = 16'd5;
        1:       limit = MaxUnitsRst;
        2:       limit = 16'd1;
        3:       limit = 16'($urandom_range(2, 16));
        4:       limit = 16'($urandom);
        default: limit = MaxUnitsRst;
      endcase
      write_max_units(limit);
      taken = 0;
      paused = 1'b0;
      while (taken < ItemsPerPhase) begin
        if (!paused && taken >= ItemsPerPhase / 2) begin
          drain_units();
          paused = 1'b1;
        end
        push_string(taken);
      end
    end

    drain_units();
    $display("Covered %0d bytes in %0d strings under %0d limit settings, idle and stall mixes.",
             bytes_sent, strings_sent, limit_writes);
    $display("Checked %0d code units and terminators.", units_checked);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_dec.sv
hw/rtl/u8u16_fifo.sv
hw/rtl/utf8_to_utf16_stream_decoder_top.sv
hw/rtl/u8u16_checker.sv
tb/tb_top.sv
